// ===== hw/rtl/udc_pkg.sv =====
// ----------------------------------------------------------------------------
// udc_pkg
// shared types and constants for the udp datagram checksum checker
// ----------------------------------------------------------------------------
package udc_pkg;

    localparam logic [15:0] PROTO_UDP  = 16'd17;
    localparam logic [16:0] HDR_BYTES  = 17'd8;
    localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;
    localparam logic [15:0] LEN_MAX    = 16'hFFFF;
    localparam logic [2:0]  IDX_FIRST  = 3'd0;
    localparam logic [2:0]  IDX_LENGTH = 3'd2;
    localparam logic [2:0]  IDX_MAX    = 3'd7;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR   = 2'd2;
    localparam logic [1:0] STATUS_CSUM_BAD  = 2'd3;

    typedef struct packed {
        logic [15:0] data_word;
        logic        is_last;
        logic        last_single_byte;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } in_word_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic [1:0]  status;
        logic [15:0] datagram_length;
    } out_word_t;

endpackage

// ===== hw/rtl/udc_accum.sv =====
// ----------------------------------------------------------------------------
// udc_accum
// running ones' complement sum, byte count and length capture per datagram
// ----------------------------------------------------------------------------
module udc_accum
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  udc_pkg::in_word_t   word,
    output udc_pkg::out_word_t  result
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [16:0] count_reg;
    logic [16:0] count_next;
    logic [15:0] hdr_len_reg;
    logic [15:0] hdr_len_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;

    logic        single;
    logic        first;
    logic [15:0] word_m;
    logic [17:0] count_sum;
    logic [15:0] len16;
    logic [18:0] pseudo;
    logic [18:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum;
    logic [15:0] hdr_eff;
    logic [1:0]  status;

    always_comb
    begin
        single = word.is_last & word.last_single_byte;
        first  = (idx_reg == udc_pkg::IDX_FIRST);
        word_m = single ? {word.data_word[15:8], 8'h00} : word.data_word;

        count_sum  = {1'b0, count_reg} + (single ? 18'd1 : 18'd2);
        count_next = count_sum[17] ? udc_pkg::COUNT_MAX : count_sum[16:0];
        len16      = count_next[16] ? udc_pkg::LEN_MAX : count_next[15:0];

        // pseudo-header on the first word
        pseudo = first ? ({3'b000, word.src_addr[31:16]} + {3'b000, word.src_addr[15:0]}
                        + {3'b000, word.dst_addr[31:16]} + {3'b000, word.dst_addr[15:0]}
                        + {3'b000, udc_pkg::PROTO_UDP}) : 19'd0;

        total = {3'b000, sum_reg} + pseudo + {3'b000, word_m}
              + (word.is_last ? {3'b000, len16} : 19'd0);
        fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        csum  = ~fold2;

        hdr_eff = (idx_reg == udc_pkg::IDX_LENGTH) ? word_m : hdr_len_reg;

        if (count_next < udc_pkg::HDR_BYTES)
            status = udc_pkg::STATUS_SHORT;
        else if (count_next[16] || (count_next[15:0] != hdr_eff))
            status = udc_pkg::STATUS_LEN_ERR;
        else if (csum != 16'd0)
            status = udc_pkg::STATUS_CSUM_BAD;
        else
            status = udc_pkg::STATUS_OK;

        result.checksum        = csum;
        result.status          = status;
        result.datagram_length = len16;

        idx_next = (idx_reg == udc_pkg::IDX_MAX) ? udc_pkg::IDX_MAX : idx_reg + 3'd1;
        sum_next = fold2;
        hdr_len_next = hdr_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= 16'd0;
            count_reg   <= 17'd0;
            hdr_len_reg <= 16'd0;
            idx_reg     <= udc_pkg::IDX_FIRST;
        end
        else if (step)
        begin
            if (word.is_last)
            begin
                sum_reg     <= 16'd0;
                count_reg   <= 17'd0;
                hdr_len_reg <= 16'd0;
                idx_reg     <= udc_pkg::IDX_FIRST;
            end
            else
            begin
                sum_reg     <= sum_next;
                count_reg   <= count_next;
                hdr_len_reg <= hdr_len_next;
                idx_reg     <= idx_next;
            end
        end
    end

endmodule

// ===== hw/rtl/udc_out_reg.sv =====
// ----------------------------------------------------------------------------
// udc_out_reg
// result register holding one word until the receiver takes it
// ----------------------------------------------------------------------------
module udc_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  udc_pkg::out_word_t  d,
    output logic                busy,
    output logic                result_valid,
    input  logic                result_ready,
    output udc_pkg::out_word_t  result
);

    logic               vld_reg;
    logic               vld_next;
    udc_pkg::out_word_t data_reg;

    always_comb
    begin
        if (load)
            vld_next = 1'b1;
        else if (result_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= d;
    end

    assign busy         = vld_reg & ~result_ready;
    assign result_valid = vld_reg;
    assign result       = data_reg;

endmodule

// ===== hw/rtl/udp_datagram_checksum_check.sv =====
// ----------------------------------------------------------------------------
// udp_datagram_checksum_check
// udp checksum and length check over a datagram streamed as 16-bit words
// ----------------------------------------------------------------------------
// item channel: one datagram word per handshake, header first, big-endian,
// is_last on the final word, last_single_byte for an odd trailing byte;
// source and destination addresses are taken with the first word
// result channel: one word per datagram, carrying the complemented sum,
// a status code and the counted length
// path: a taken word is held in the input register, then folded into the
// accumulator registers; a last word instead loads the result register
// throughput: one word per cycle while no last word is stalled, set by the
// combinational sum and count update between the input and result registers
// stall: a last word waits in the input register while a result is held
// and not taken; other words keep flowing
// reset: all sums and counts clear, both registers empty, next word is
// the first of a datagram
// ----------------------------------------------------------------------------
module udp_datagram_checksum_check
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  udc_pkg::in_word_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output udc_pkg::out_word_t  result
);

    logic               in_vld_reg;
    logic               in_vld_next;
    udc_pkg::in_word_t  in_data_reg;
    logic               out_busy;
    logic               advance;
    udc_pkg::out_word_t acc_result;

    assign advance     = in_vld_reg & (~in_data_reg.is_last | ~out_busy);
    assign item_ready  = ~in_vld_reg | advance;
    assign in_vld_next = item_ready ? item_valid : in_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_data_reg <= item;
    end

    udc_accum u_accum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_data_reg),
        .result (acc_result)
    );

    udc_out_reg u_out_reg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance & in_data_reg.is_last),
        .d            (acc_result),
        .busy         (out_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
